// ----- rtl/sem_pkg.sv -----
package sem_pkg;

   // Frame limits and derived widths
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int IN_ROW_W   = $clog2(MAX_HEIGHT + 2);
   localparam int OUT_ROW_W  = $clog2(MAX_HEIGHT + 1);

   // Field widths
   localparam int DIM_W      = 11;
   localparam int WEIGHT_W   = 9;
   localparam int PIX_W      = 8;
   localparam int PROD_W     = WEIGHT_W + PIX_W;
   localparam int GSUM_W     = PROD_W + 2;
   localparam int CSR_DATA_W = 11;
   localparam int CSR_IDX_W  = 3;

   // Gradient and root widths
   localparam int GRAD_W     = PIX_W + 2;
   localparam int SQ_W       = 2 * GRAD_W;
   localparam int ROOT_W     = 16;
   localparam int ROOT_STEPS = ROOT_W / 2;
   localparam int STEP_W     = $clog2(ROOT_STEPS);
   localparam logic [PIX_W-1:0] PIX_MAX = '1;

   // Reset values of the registers
   localparam logic [DIM_W-1:0]    RST_WIDTH  = DIM_W'(640);
   localparam logic [DIM_W-1:0]    RST_HEIGHT = DIM_W'(480);
   localparam logic [WEIGHT_W-1:0] RST_RED    = WEIGHT_W'(77);
   localparam logic [WEIGHT_W-1:0] RST_GREEN  = WEIGHT_W'(150);
   localparam logic [WEIGHT_W-1:0] RST_BLUE   = WEIGHT_W'(29);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH  = 3'd0,
      CSR_FRAME_HEIGHT = 3'd1,
      CSR_WEIGHT_RED   = 3'd2,
      CSR_WEIGHT_GREEN = 3'd3,
      CSR_WEIGHT_BLUE  = 3'd4
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COMMIT,
      ST_GRAD,
      ST_SQUARE,
      ST_ROOT_INIT,
      ST_ROOT,
      ST_DONE
   } sem_state_type;

   typedef struct packed {
      logic load;
      logic commit;
      logic grad;
      logic square;
      logic root_init;
      logic root_step;
      logic out_load;
   } sem_cmd_type;

   typedef struct packed {
      logic produce;
      logic root_last;
      logic out_free;
   } sem_status_type;

endpackage

// ----- rtl/sem_req_if.sv -----
interface sem_req_if;
   import sem_pkg::*;

   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] red;
   logic [PIX_W-1:0] green;
   logic [PIX_W-1:0] blue;
   logic             flush;

   modport source (output valid, output red, output green, output blue, output flush,
                   input ready);
   modport sink   (input valid, input red, input green, input blue, input flush,
                   output ready);
endinterface

// ----- rtl/sem_rsp_if.sv -----
interface sem_rsp_if;
   import sem_pkg::*;

   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] magnitude;
   logic             end_of_frame;

   modport source (output valid, output magnitude, output end_of_frame, input ready);
   modport sink   (input valid, input magnitude, input end_of_frame, output ready);
endinterface

// ----- rtl/sem_ram.sv -----
module sem_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- rtl/sem_ctrl.sv -----
module sem_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  sem_pkg::sem_status_type status,
   output sem_pkg::sem_cmd_type    cmd
);
   import sem_pkg::*;

   sem_state_type state_ff;
   sem_state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = status.produce ? ST_GRAD : ST_IDLE;
         end
         ST_GRAD: begin
            cmd.grad = 1'b1;
            state_in = ST_SQUARE;
         end
         ST_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = ST_ROOT_INIT;
         end
         ST_ROOT_INIT: begin
            cmd.root_init = 1'b1;
            state_in      = ST_ROOT;
         end
         ST_ROOT: begin
            cmd.root_step = 1'b1;
            if (status.root_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // Hold the result until the output slot is free
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end
endmodule

// ----- rtl/sem_datapath.sv -----
module sem_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [sem_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sem_pkg::CSR_DATA_W-1:0]   csr_wr_data,
   input  logic [sem_pkg::PIX_W-1:0]        red,
   input  logic [sem_pkg::PIX_W-1:0]        green,
   input  logic [sem_pkg::PIX_W-1:0]        blue,
   input  logic                             flush,
   input  sem_pkg::sem_cmd_type             cmd,
   output sem_pkg::sem_status_type          status,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [sem_pkg::PIX_W-1:0]        magnitude,
   output logic                             end_of_frame
);
   import sem_pkg::*;

   // Clamp a frame dimension to 1..limit
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v, input int limit);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (int'(v) > limit) begin
         r = DIM_W'(limit);
      end else begin
         r = v;
      end
      return r;
   endfunction

   // Configuration registers
   logic [DIM_W-1:0]    width_cfg_ff, height_cfg_ff;
   logic [WEIGHT_W-1:0] wr_ff, wg_ff, wb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_cfg_ff  <= RST_WIDTH;
         height_cfg_ff <= RST_HEIGHT;
         wr_ff         <= RST_RED;
         wg_ff         <= RST_GREEN;
         wb_ff         <= RST_BLUE;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_FRAME_WIDTH:  width_cfg_ff  <= csr_wr_data;
            CSR_FRAME_HEIGHT: height_cfg_ff <= csr_wr_data;
            CSR_WEIGHT_RED:   wr_ff <= csr_wr_data[WEIGHT_W-1:0];
            CSR_WEIGHT_GREEN: wg_ff <= csr_wr_data[WEIGHT_W-1:0];
            CSR_WEIGHT_BLUE:  wb_ff <= csr_wr_data[WEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   // Position counters and the frame size latched at the first item
   logic [DIM_W-1:0]     cur_w_ff, cur_w_in, cur_h_ff, cur_h_in;
   logic [COL_W-1:0]     in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [IN_ROW_W-1:0]  in_row_ff, in_row_in;
   logic [OUT_ROW_W-1:0] out_row_ff, out_row_in;
   logic                 at_last_col, out_last_col, out_last_row, eof_now;

   assign at_last_col  = 32'(in_col_ff) + 32'd1 >= 32'(cur_w_ff);
   assign out_last_col = 32'(out_col_ff) + 32'd1 >= 32'(cur_w_ff);
   assign out_last_row = 32'(out_row_ff) + 32'd1 >= 32'(cur_h_ff);
   assign eof_now      = out_last_row && out_last_col;

   assign status.produce = (in_row_ff > IN_ROW_W'(1))
                           || (in_row_ff == IN_ROW_W'(1) && in_col_ff != '0);

   always_comb begin
      cur_w_in   = cur_w_ff;
      cur_h_in   = cur_h_ff;
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (cmd.load && in_row_ff == '0 && in_col_ff == '0) begin
         cur_w_in = clamp_dim(width_cfg_ff, MAX_WIDTH);
         cur_h_in = clamp_dim(height_cfg_ff, MAX_HEIGHT);
      end
      if (cmd.commit) begin
         if (status.produce && eof_now) begin
            in_col_in  = '0;
            in_row_in  = '0;
            out_col_in = '0;
            out_row_in = '0;
         end else begin
            if (status.produce) begin
               if (out_last_col) begin
                  out_col_in = '0;
                  out_row_in = out_row_ff + OUT_ROW_W'(1);
               end else begin
                  out_col_in = out_col_ff + COL_W'(1);
               end
            end
            if (at_last_col) begin
               in_col_in = '0;
               in_row_in = in_row_ff + IN_ROW_W'(1);
            end else begin
               in_col_in = in_col_ff + COL_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_w_ff   <= clamp_dim(RST_WIDTH, MAX_WIDTH);
         cur_h_ff   <= clamp_dim(RST_HEIGHT, MAX_HEIGHT);
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else begin
         cur_w_ff   <= cur_w_in;
         cur_h_ff   <= cur_h_in;
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
      end
   end

   // Weighted products, taken with the item
   logic [PROD_W-1:0] prod_r_ff, prod_g_ff, prod_b_ff;
   logic              flush_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         prod_r_ff <= PROD_W'(wr_ff * red);
         prod_g_ff <= PROD_W'(wg_ff * green);
         prod_b_ff <= PROD_W'(wb_ff * blue);
         flush_ff  <= flush;
      end
   end

   // Gray value: scale, saturate, force black on flush
   logic [GSUM_W-1:0]     gray_sum;
   logic [GSUM_W-9:0]     gray_scaled;
   logic [PIX_W-1:0]      gray;

   always_comb begin
      gray_sum    = GSUM_W'(prod_r_ff) + GSUM_W'(prod_g_ff) + GSUM_W'(prod_b_ff);
      gray_scaled = gray_sum[GSUM_W-1:8];
      if (flush_ff) begin
         gray = '0;
      end else if (gray_scaled > (GSUM_W-8)'(PIX_MAX)) begin
         gray = PIX_MAX;
      end else begin
         gray = gray_scaled[PIX_W-1:0];
      end
   end

   // Line buffers: upper byte is the older line, lower byte the newer
   logic [2*PIX_W-1:0] line_rd;
   logic [PIX_W-1:0]   line_old, line_new;

   assign line_old = line_rd[2*PIX_W-1:PIX_W];
   assign line_new = line_rd[PIX_W-1:0];

   sem_ram #(
      .WIDTH (2 * PIX_W),
      .DEPTH (MAX_WIDTH)
   ) u_lines (
      .clock   (clock),
      .wr_en   (cmd.commit),
      .wr_addr (in_col_ff),
      .wr_data ({line_new, gray}),
      .rd_en   (cmd.load),
      .rd_addr (in_col_ff),
      .rd_data (line_rd)
   );

   // Sliding window and the padding flags of the output position
   logic [PIX_W-1:0] win_ff [3][3];
   logic             top_ff, bot_ff, left_ff, right_ff, eof_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               win_ff[i][j] <= '0;
            end
         end
      end else if (cmd.commit) begin
         for (int i = 0; i < 3; i++) begin
            win_ff[i][0] <= win_ff[i][1];
            win_ff[i][1] <= win_ff[i][2];
         end
         win_ff[0][2] <= line_old;
         win_ff[1][2] <= line_new;
         win_ff[2][2] <= gray;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         top_ff   <= out_row_ff == '0;
         bot_ff   <= out_last_row;
         left_ff  <= out_col_ff == '0;
         right_ff <= out_last_col;
         eof_ff   <= eof_now;
      end
   end

   // Sobel gradients as absolute values
   logic [PIX_W-1:0]  vm [3][3];
   logic [GRAD_W-1:0] pos_x, neg_x, pos_y, neg_y;
   logic [GRAD_W-1:0] abs_x_ff, abs_y_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            if ((i == 0 && top_ff) || (i == 2 && bot_ff) ||
                (j == 0 && left_ff) || (j == 2 && right_ff)) begin
               vm[i][j] = '0;
            end else begin
               vm[i][j] = win_ff[i][j];
            end
         end
      end
      pos_x = GRAD_W'(vm[0][2]) + {1'b0, vm[1][2], 1'b0} + GRAD_W'(vm[2][2]);
      neg_x = GRAD_W'(vm[0][0]) + {1'b0, vm[1][0], 1'b0} + GRAD_W'(vm[2][0]);
      pos_y = GRAD_W'(vm[2][0]) + {1'b0, vm[2][1], 1'b0} + GRAD_W'(vm[2][2]);
      neg_y = GRAD_W'(vm[0][0]) + {1'b0, vm[0][1], 1'b0} + GRAD_W'(vm[0][2]);
   end

   always_ff @(posedge clock) begin
      if (cmd.grad) begin
         abs_x_ff <= (pos_x >= neg_x) ? pos_x - neg_x : neg_x - pos_x;
         abs_y_ff <= (pos_y >= neg_y) ? pos_y - neg_y : neg_y - pos_y;
      end
   end

   // Squares
   logic [SQ_W-1:0] sq_x_ff, sq_y_ff;

   always_ff @(posedge clock) begin
      if (cmd.square) begin
         sq_x_ff <= abs_x_ff * abs_x_ff;
         sq_y_ff <= abs_y_ff * abs_y_ff;
      end
   end

   // Integer square root, one result bit per step
   logic [SQ_W:0]       sq_sum;
   logic [ROOT_W-1:0]   rem_ff, rem_in, res_ff, res_in;
   logic [ROOT_W-2:0]   root_bit_ff, root_bit_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic                big_ff, big_in;
   logic [ROOT_W:0]     trial;

   assign sq_sum = (SQ_W+1)'(sq_x_ff) + (SQ_W+1)'(sq_y_ff);
   assign trial  = (ROOT_W+1)'(res_ff) + (ROOT_W+1)'(root_bit_ff);

   always_comb begin
      rem_in      = rem_ff;
      res_in      = res_ff;
      root_bit_in = root_bit_ff;
      step_in     = step_ff;
      big_in      = big_ff;
      if (cmd.root_init) begin
         rem_in      = sq_sum[ROOT_W-1:0];
         big_in      = sq_sum[SQ_W:ROOT_W] != '0;
         res_in      = '0;
         root_bit_in = {1'b1, {(ROOT_W-2){1'b0}}};
         step_in     = '0;
      end else if (cmd.root_step) begin
         if ({1'b0, rem_ff} >= trial) begin
            rem_in = rem_ff - trial[ROOT_W-1:0];
            res_in = (res_ff >> 1) + ROOT_W'(root_bit_ff);
         end else begin
            res_in = res_ff >> 1;
         end
         root_bit_in = root_bit_ff >> 2;
         step_in     = step_ff + STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      rem_ff      <= rem_in;
      res_ff      <= res_in;
      root_bit_ff <= root_bit_in;
      step_ff     <= step_in;
      big_ff      <= big_in;
   end

   assign status.root_last = step_ff == STEP_W'(ROOT_STEPS - 1);

   // Output register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0] mag_ff, mag_in;
   logic             rsp_eof_ff, rsp_eof_in;

   assign status.out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      mag_in       = mag_ff;
      rsp_eof_in   = rsp_eof_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         mag_in       = big_ff ? PIX_MAX : res_ff[PIX_W-1:0];
         rsp_eof_in   = eof_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      mag_ff     <= mag_in;
      rsp_eof_ff <= rsp_eof_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign magnitude    = mag_ff;
   assign end_of_frame = rsp_eof_ff;
endmodule

// ----- rtl/sobel_edge_magnitude.sv -----
// Flow: an item that yields no result retires from the commit state; a result passes the
// gradient, square, root-init, root and done states before it reaches the output register
// (square root takes one result bit per cycle, 8 steps). A new item is taken only in the
// idle state, after the last one has retired; a stalled output holds it in the done state.
// Reset: synchronous, active high; registers return to their default values, counters
// and window clear, the line buffers are not cleared and hold garbage until written.
module sobel_edge_magnitude (
   input  logic                           clock,
   input  logic                           reset,
   sem_req_if.sink                        req_chan,
   sem_rsp_if.source                      rsp_chan,
   input  logic                           csr_wr_en,
   input  logic [sem_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sem_pkg::CSR_DATA_W-1:0] csr_wr_data
);
   import sem_pkg::*;

   sem_cmd_type    cmd;
   sem_status_type status;

   // Controller
   sem_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath
   sem_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wr_data  (csr_wr_data),
      .red          (req_chan.red),
      .green        (req_chan.green),
      .blue         (req_chan.blue),
      .flush        (req_chan.flush),
      .cmd          (cmd),
      .status       (status),
      .rsp_valid    (rsp_chan.valid),
      .rsp_ready    (rsp_chan.ready),
      .magnitude    (rsp_chan.magnitude),
      .end_of_frame (rsp_chan.end_of_frame)
   );

`ifndef SYNTH
   a_commit_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> cmd.commit)
      else $error("commit did not follow an accepted item");

   a_single_command: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.commit, cmd.grad, cmd.square, cmd.root_init,
                cmd.root_step, cmd.out_load}))
      else $error("more than one datapath command at once");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.ready) |-> !cmd.out_load)
      else $error("result loaded over an untaken result");
`endif
endmodule

// ----- dv/testbench.sv -----
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import sem_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int SETTLE_CYCLES  = 20;
   localparam int TAIL_CYCLES    = 40;
   localparam int MAX_REPORTS    = 10;

   typedef struct packed {
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
      logic             flush;
   } pixel_item_type;

   typedef struct packed {
      logic [PIX_W-1:0] magnitude;
      logic             end_of_frame;
   } edge_result_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;

   sem_req_if req_bus ();
   sem_rsp_if rsp_bus ();

   sobel_edge_magnitude DUT (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // Register copies seen by the edge model
   logic [DIM_W-1:0]    cfg_width  = RST_WIDTH;
   logic [DIM_W-1:0]    cfg_height = RST_HEIGHT;
   logic [WEIGHT_W-1:0] wt_red     = RST_RED;
   logic [WEIGHT_W-1:0] wt_green   = RST_GREEN;
   logic [WEIGHT_W-1:0] wt_blue    = RST_BLUE;

   // Edge model state
   logic [PIX_W-1:0] line_mem [2][MAX_WIDTH];
   logic [PIX_W-1:0] win [3][3];
   int unsigned      in_col, in_row, out_col, out_row;
   int unsigned      frame_w, frame_h;

   edge_result_type pending_edges [$];
   int              mismatch_count = 0;
   int              idle_pct       = 0;
   int              stall_pct      = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] value,
                                             input int unsigned limit);
      if (value == '0) return 1;
      if (value > limit) return limit;
      return value;
   endfunction

   function automatic pixel_item_type make_pixel(input int r, input int g, input int b,
                                                 input bit fl);
      pixel_item_type px;
      px.red   = PIX_W'(r);
      px.green = PIX_W'(g);
      px.blue  = PIX_W'(b);
      px.flush = fl;
      return px;
   endfunction

   // Advance the gray window by one item and queue the magnitude it yields
   function automatic void step_edge_window(input pixel_item_type px);
      int unsigned      gray, col;
      logic [PIX_W-1:0] top, mid;
      int               tap [3][3];
      int               gx, gy, sq_sum;
      logic [PIX_W-1:0] root, trial;
      edge_result_type  res;

      // latch the frame size on the first item of a frame
      if (in_row == 0 && in_col == 0) begin
         frame_w = clamp_dim(cfg_width, MAX_WIDTH);
         frame_h = clamp_dim(cfg_height, MAX_HEIGHT);
      end

      // weighted luma, saturated; flush forces black
      gray = (int'(wt_red) * int'(px.red) + int'(wt_green) * int'(px.green)
              + int'(wt_blue) * int'(px.blue)) >> 8;
      if (gray > 255) gray = 255;
      if (px.flush) gray = 0;

      // rotate the line buffers at this column
      col = (in_col < MAX_WIDTH) ? in_col : MAX_WIDTH - 1;
      top = line_mem[0][col];
      mid = line_mem[1][col];
      line_mem[0][col] = mid;
      line_mem[1][col] = PIX_W'(gray);

      for (int i = 0; i < 3; i++) begin
         win[i][0] = win[i][1];
         win[i][1] = win[i][2];
      end
      win[0][2] = top;
      win[1][2] = mid;
      win[2][2] = PIX_W'(gray);

      if (in_row > 1 || (in_row == 1 && in_col >= 1)) begin
         // zero the taps that fall outside the frame
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               if ((i == 0 && out_row == 0) || (i == 2 && out_row + 1 >= frame_h) ||
                   (j == 0 && out_col == 0) || (j == 2 && out_col + 1 >= frame_w))
                  tap[i][j] = 0;
               else
                  tap[i][j] = int'(win[i][j]);
            end
         end
         gx = tap[0][2] + 2 * tap[1][2] + tap[2][2] - tap[0][0] - 2 * tap[1][0] - tap[2][0];
         gy = tap[2][0] + 2 * tap[2][1] + tap[2][2] - tap[0][0] - 2 * tap[0][1] - tap[0][2];
         sq_sum = gx * gx + gy * gy;

         // floor root, one bit at a time; saturates at the top code
         root = '0;
         for (int b = PIX_W - 1; b >= 0; b--) begin
            trial = root | (PIX_W'(1) << b);
            if (int'(trial) * int'(trial) <= sq_sum) root = trial;
         end

         res.magnitude    = root;
         res.end_of_frame = (out_row + 1 >= frame_h) && (out_col + 1 >= frame_w);
         pending_edges.push_back(res);

         if (res.end_of_frame) begin
            in_col  = 0;
            in_row  = 0;
            out_col = 0;
            out_row = 0;
            return;
         end
         out_col++;
         if (out_col >= frame_w) begin
            out_col = 0;
            out_row++;
         end
      end

      in_col++;
      if (in_col >= frame_w) begin
         in_col = 0;
         in_row++;
      end
   endfunction

   // Offer one item after a random gap and hold it until accepted
   task automatic send_pixel(input pixel_item_type px);
      while ($urandom_range(99) < idle_pct) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid = 1'b1;
      req_bus.red   = px.red;
      req_bus.green = px.green;
      req_bus.blue  = px.blue;
      req_bus.flush = px.flush;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      step_edge_window(px);
      @(negedge clock);
   endtask

   // Drop valid, wait out every pending result and the pipeline tail
   task automatic drain_results();
      req_bus.valid = 1'b0;
      while (pending_edges.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_wr_en   = 1'b1;
      csr_index   = idx;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en   = 1'b0;
      case (idx)
         CSR_FRAME_WIDTH:  cfg_width  = value[DIM_W-1:0];
         CSR_FRAME_HEIGHT: cfg_height = value[DIM_W-1:0];
         CSR_WEIGHT_RED:   wt_red     = value[WEIGHT_W-1:0];
         CSR_WEIGHT_GREEN: wt_green   = value[WEIGHT_W-1:0];
         CSR_WEIGHT_BLUE:  wt_blue    = value[WEIGHT_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_frame(input int width, input int height);
      write_csr(CSR_FRAME_WIDTH, CSR_DATA_W'(width));
      write_csr(CSR_FRAME_HEIGHT, CSR_DATA_W'(height));
   endtask

   // Unused upper data bits carry random junk
   task automatic set_weights(input int red_w, input int green_w, input int blue_w);
      write_csr(CSR_WEIGHT_RED,
                (CSR_DATA_W'($urandom_range(3)) << WEIGHT_W) | CSR_DATA_W'(red_w));
      write_csr(CSR_WEIGHT_GREEN,
                (CSR_DATA_W'($urandom_range(3)) << WEIGHT_W) | CSR_DATA_W'(green_w));
      write_csr(CSR_WEIGHT_BLUE,
                (CSR_DATA_W'($urandom_range(3)) << WEIGHT_W) | CSR_DATA_W'(blue_w));
   endtask

   // One whole frame of random pixels plus its drain items; noise flips the flush bit
   task automatic send_frame(input int noise_pct, output int sent);
      int unsigned    w, h, pixels;
      pixel_item_type px;
      w      = clamp_dim(cfg_width, MAX_WIDTH);
      h      = clamp_dim(cfg_height, MAX_HEIGHT);
      pixels = w * h;
      sent   = pixels + w + 1;
      for (int k = 0; k < sent; k++) begin
         px.red   = PIX_W'($urandom_range(255));
         px.green = PIX_W'($urandom_range(255));
         px.blue  = PIX_W'($urandom_range(255));
         if (k < pixels)
            px.flush = ($urandom_range(99) < noise_pct);
         else
            px.flush = !($urandom_range(99) < noise_pct);
         send_pixel(px);
      end
   endtask

   // Hand-picked pixels on a 3x3 and a 1x1 frame at the reset weights
   task automatic test_directed_pixels();
      drain_results();
      set_frame(3, 3);
      send_pixel(make_pixel(255, 255, 255, 0));
      send_pixel(make_pixel(0, 0, 0, 0));
      send_pixel(make_pixel(255, 0, 0, 0));
      send_pixel(make_pixel(0, 255, 0, 0));
      // flush inside the frame reads as black
      send_pixel(make_pixel(255, 255, 255, 1));
      send_pixel(make_pixel(0, 0, 255, 0));
      send_pixel(make_pixel(255, 255, 255, 0));
      send_pixel(make_pixel(128, 64, 32, 0));
      send_pixel(make_pixel(0, 0, 0, 0));
      // drain items; the plain pixels among them act as flushes
      send_pixel(make_pixel(255, 255, 255, 0));
      send_pixel(make_pixel(0, 0, 0, 1));
      send_pixel(make_pixel(170, 85, 255, 1));
      send_pixel(make_pixel(85, 170, 0, 0));

      drain_results();
      set_frame(1, 1);
      send_pixel(make_pixel(255, 255, 255, 0));
      send_pixel(make_pixel(0, 0, 0, 1));
      send_pixel(make_pixel(255, 255, 255, 1));
   endtask

   // Zero, unity and overflowing luma weights
   task automatic test_weight_extremes();
      int sent;
      int weight_sets [6][3] = '{'{0, 0, 0}, '{256, 256, 256}, '{511, 511, 511},
                                 '{256, 0, 0}, '{0, 256, 0}, '{0, 0, 256}};
      for (int s = 0; s < 6; s++) begin
         drain_results();
         set_frame(3, 2);
         set_weights(weight_sets[s][0], weight_sets[s][1], weight_sets[s][2]);
         send_frame(10, sent);
      end
   endtask

   // Zero and oversized frame dimensions fold into the legal range
   task automatic test_frame_extremes();
      int sent;
      int dims [3][2] = '{'{0, 3}, '{1, 0}, '{0, 2047}};
      for (int s = 0; s < 3; s++) begin
         drain_results();
         set_frame(dims[s][0], dims[s][1]);
         set_weights($urandom_range(511), $urandom_range(511), $urandom_range(511));
         send_frame(0, sent);
      end
   endtask

   // Random frames under one idling profile
   task automatic test_random_frames(input int sender_idle, input int receiver_stall,
                                     input int budget);
      int sent, total, w, h, wr, wg, noise;
      idle_pct  = sender_idle;
      stall_pct = receiver_stall;
      total     = 0;
      while (total < budget) begin
         drain_results();
         if ($urandom_range(99) < 85) begin
            w = $urandom_range(1, 8);
            h = $urandom_range(1, 6);
         end else begin
            w = $urandom_range(1, 48);
            h = $urandom_range(1, 16);
         end
         set_frame(w, h);
         if ($urandom_range(99) < 30) begin
            set_weights($urandom_range(511), $urandom_range(511), $urandom_range(511));
         end else begin
            wr = $urandom_range(20, 100);
            wg = $urandom_range(60, 150);
            set_weights(wr, wg, $urandom_range(256 - wr - wg));
         end
         noise = ($urandom_range(99) < 20) ? $urandom_range(10, 50) : 0;
         send_frame(noise, sent);
         total += sent;
      end
      idle_pct  = 0;
      stall_pct = 0;
   endtask

   // Receiver back-pressure
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready = ($urandom_range(99) >= stall_pct);
      end
   end

   // Compare each accepted result with the oldest expectation
   always @(posedge clock) begin : result_check
      edge_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_edges.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("unexpected result: magnitude %0d end_of_frame %0b",
                        rsp_bus.magnitude, rsp_bus.end_of_frame);
         end else begin
            want = pending_edges.pop_front();
            if (rsp_bus.magnitude !== want.magnitude ||
                rsp_bus.end_of_frame !== want.end_of_frame) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("mismatch: expected magnitude %0d eof %0b, got magnitude %0d eof %0b",
                           want.magnitude, want.end_of_frame,
                           rsp_bus.magnitude, rsp_bus.end_of_frame);
            end
         end
      end
   end

   // End the run when nothing moves for too long
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("FAIL sobel_edge_magnitude");
      $finish;
   end

   initial begin : main_sequence
      reset         = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.red   = '0;
      req_bus.green = '0;
      req_bus.blue  = '0;
      req_bus.flush = 1'b0;
      csr_wr_en     = 1'b0;
      csr_index     = CSR_FRAME_WIDTH;
      csr_wr_data   = '0;
      for (int c = 0; c < MAX_WIDTH; c++) begin
         line_mem[0][c] = '0;
         line_mem[1][c] = '0;
      end
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++)
            win[i][j] = '0;
      in_col  = 0;
      in_row  = 0;
      out_col = 0;
      out_row = 0;
      frame_w = clamp_dim(RST_WIDTH, MAX_WIDTH);
      frame_h = clamp_dim(RST_HEIGHT, MAX_HEIGHT);

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_pixels();
      test_weight_extremes();
      test_frame_extremes();
      test_random_frames(0, 0, 100);
      test_random_frames(75, 0, 100);
      test_random_frames(0, 75, 100);
      test_random_frames(12, 12, 100);

      // wait for the last results, then watch for strays
      req_bus.valid = 1'b0;
      while (pending_edges.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && pending_edges.size() == 0)
         $display("PASS sobel_edge_magnitude");
      else
         $display("FAIL sobel_edge_magnitude");
      $finish;
   end

endmodule

// ----- sobel_edge_magnitude.f -----
rtl/sem_pkg.sv
rtl/sem_req_if.sv
rtl/sem_rsp_if.sv
rtl/sem_ram.sv
rtl/sem_ctrl.sv
rtl/sem_datapath.sv
rtl/sobel_edge_magnitude.sv
dv/testbench.sv
